### rtl/kmms_pkg.sv
// kmms_pkg: field widths, stream packing and constants for the k-way merge block
// no dependencies; used by kway_merge_min_select
package kmms_pkg;

	localparam int RUN_W = 4;
	localparam int KEY_W = 31;
	localparam int PAY_W = 64;
	localparam int CFG_W = 5;

	// key value reserved as end-of-run marker
	localparam logic [KEY_W-1:0] END_KEY = {KEY_W{1'b1}};

	// stream packing in tdata, lowest field first: input run/key/payload, output key/payload/run
	localparam int IN_BITS    = RUN_W + KEY_W + PAY_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS    = KEY_W + PAY_W + RUN_W;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// register reset value for the number of merged runs
	localparam logic [CFG_W-1:0] RUNS_RESET = CFG_W'(2);

endpackage

### rtl/kway_merge_min_select.sv
// kway_merge_min_select: k-way merge of sorted runs with a sequential minimum scan
// depends on kmms_pkg and kmms_ram
//
// The block holds one head record per run. Each input item either delivers the
// next record of a run (key, payload) or, with tlast set or the all-ones key,
// marks that run as ended. Once every run in use holds a head or has ended, the
// heads are scanned one slot per cycle through a single comparator and the
// smallest key is emitted (ties go to the lowest run index); refill_run then
// names the run whose next record is wanted. When every run has ended a single
// done item (tlast high, tuser low) is emitted and all slots clear for the next
// merge. An item that is ignored (run not in use, slot already occupied or
// ended) is consumed with no effect; an item that leaves some run still empty
// goes through the check state back to idle; an item that triggers a result
// goes through check, a scan of the clamped runs_in_use slots of the head ram
// with its registered read, and emit. No clearing pass is needed after reset.
// The result sits in an output register; a new item may be taken while it
// waits, and a further result stalls only while that register is still occupied.
// runs_in_use below 2 acts as 2 and above MAX_RUNS acts as MAX_RUNS.
module kway_merge_min_select #(
	parameter int MAX_RUNS     = 16,
	parameter int PAYLOAD_BITS = 64
) (
	input  logic clk,
	input  logic arst_n,

	// configuration: runs_in_use
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [kmms_pkg::CFG_W-1:0] cfg_data,

	// input items
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [kmms_pkg::IN_TDATA_W-1:0]  s_tdata,  // run_index, rec_key, rec_payload, zero pad
	input  logic                             s_tlast,  // run_ended

	// result items
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [kmms_pkg::OUT_TDATA_W-1:0] m_tdata,  // out_key, out_payload, refill_run, zero pad
	output logic [0:0]                       m_tuser,  // out_valid
	output logic                             m_tlast   // merge_done
);

	localparam int IDX_W = $clog2(MAX_RUNS);
	localparam int CNT_W = $clog2(MAX_RUNS + 1);
	localparam int REC_W = kmms_pkg::KEY_W + PAYLOAD_BITS;

	// sequencer states
	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CHECK = 2'd1;
	localparam logic [1:0] ST_SCAN  = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	logic [1:0] state_q;

	logic [kmms_pkg::CFG_W-1:0] runs_q;
	logic [CNT_W-1:0]           n_runs;
	logic [31:0]                runs_ext;

	// per-slot status
	logic [MAX_RUNS-1:0] full_q;
	logic [MAX_RUNS-1:0] ended_q;

	// unpacked input fields
	logic [kmms_pkg::RUN_W-1:0] in_run;
	logic [kmms_pkg::KEY_W-1:0] in_key;
	logic [kmms_pkg::PAY_W-1:0] in_pay;
	logic [IDX_W-1:0]           in_slot;
	logic                       in_end;
	logic                       s_accept;
	logic                       in_ok;

	logic all_ready;

	// scan pipeline
	logic [CNT_W-1:0] scan_idx_q;
	logic             scan_issue;
	logic             rd_vld_s1;
	logic             rd_last_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [REC_W-1:0] rd_data;
	logic [kmms_pkg::KEY_W-1:0] rd_key;
	logic [PAYLOAD_BITS-1:0]    rd_pay;
	logic             take_rd;

	// running minimum
	logic                       any_q;
	logic [IDX_W-1:0]           best_idx_q;
	logic [kmms_pkg::KEY_W-1:0] best_key_q;
	logic [PAYLOAD_BITS-1:0]    best_pay_q;

	// output register
	logic                             m_tvalid_q;
	logic [kmms_pkg::OUT_TDATA_W-1:0] m_tdata_q;
	logic                             m_tuser_q;
	logic                             m_tlast_q;
	logic                             out_busy;
	logic                             emit_go;

	// clamp the register value to the supported run count
	assign runs_ext = 32'(runs_q);
	always_comb begin
		if (runs_ext < 32'd2) begin
			n_runs = CNT_W'(2);
		end else if (runs_ext > 32'(MAX_RUNS)) begin
			n_runs = CNT_W'(MAX_RUNS);
		end else begin
			n_runs = CNT_W'(runs_ext);
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			runs_q <= kmms_pkg::RUNS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			runs_q <= cfg_data;
		end
	end

	// input unpacking
	assign in_run  = s_tdata[kmms_pkg::RUN_W-1:0];
	assign in_key  = s_tdata[kmms_pkg::RUN_W +: kmms_pkg::KEY_W];
	assign in_pay  = s_tdata[kmms_pkg::RUN_W + kmms_pkg::KEY_W +: kmms_pkg::PAY_W];
	assign in_slot = IDX_W'(in_run);
	assign in_end  = s_tlast || (in_key == kmms_pkg::END_KEY);

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;

	// run in use and its slot still waiting for a record
	assign in_ok = (32'(in_run) < 32'(n_runs)) && !full_q[in_slot] && !ended_q[in_slot];

	// every run in use holds a head or has ended
	always_comb begin
		all_ready = 1'b1;
		for (int i = 0; i < MAX_RUNS; i++) begin
			if ((i < 32'(n_runs)) && !full_q[i] && !ended_q[i]) begin
				all_ready = 1'b0;
			end
		end
	end

	// head records live in a small ram, read one slot per scan cycle
	assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q < n_runs);

	kmms_ram #(
		.WIDTH(REC_W),
		.DEPTH(MAX_RUNS)
	) u_heads (
		.clk    (clk),
		.wr_en  (s_accept && in_ok && !in_end),
		.wr_addr(in_slot),
		.wr_data({in_pay[PAYLOAD_BITS-1:0], in_key}),
		.rd_en  (scan_issue),
		.rd_addr(scan_idx_q[IDX_W-1:0]),
		.rd_data(rd_data)
	);

	assign rd_key  = rd_data[kmms_pkg::KEY_W-1:0];
	assign rd_pay  = rd_data[kmms_pkg::KEY_W +: PAYLOAD_BITS];
	// strict less-than keeps the lowest index on ties
	assign take_rd = rd_vld_s1 && full_q[rd_idx_s1] && (!any_q || (rd_key < best_key_q));

	assign out_busy = m_tvalid_q && !m_tready;
	assign emit_go  = (state_q == ST_EMIT) && !out_busy;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			any_q      <= 1'b0;
		end else begin
			rd_vld_s1  <= scan_issue;
			rd_last_s1 <= scan_issue && (scan_idx_q == (n_runs - CNT_W'(1)));
			unique case (state_q)
				ST_IDLE: begin
					if (s_accept && in_ok) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					scan_idx_q <= '0;
					any_q      <= 1'b0;
					state_q    <= all_ready ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end
					if (take_rd) begin
						any_q <= 1'b1;
					end
					if (rd_vld_s1 && rd_last_s1) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// scan bookkeeping and best-candidate payload need no reset
	always_ff @(posedge clk) begin
		rd_idx_s1 <= scan_idx_q[IDX_W-1:0];
		if (take_rd) begin
			best_idx_q <= rd_idx_s1;
			best_key_q <= rd_key;
			best_pay_q <= rd_pay;
		end
	end

	// slot status flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= '0;
			ended_q <= '0;
		end else if (s_accept && in_ok) begin
			if (in_end) begin
				ended_q[in_slot] <= 1'b1;
			end else begin
				full_q[in_slot] <= 1'b1;
			end
		end else if (emit_go) begin
			if (any_q) begin
				full_q[best_idx_q] <= 1'b0;
			end else begin
				// merge finished: clear every slot for the next pass
				full_q  <= '0;
				ended_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			m_tuser_q <= any_q;
			m_tlast_q <= !any_q;
			if (any_q) begin
				m_tdata_q <= kmms_pkg::OUT_TDATA_W'({
					kmms_pkg::RUN_W'(best_idx_q),
					kmms_pkg::PAY_W'(best_pay_q),
					best_key_q
				});
			end else begin
				m_tdata_q <= '0;
			end
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;
	assign m_tlast    = m_tlast_q;

	// a slot never holds a head and an end mark at once
	a_slot_excl: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q & ended_q) == '0)
		else $error("slot both full and ended");

	// the scan never reads past the runs in use
	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> (32'(rd_idx_s1) < 32'(n_runs)))
		else $error("scan index out of range");

	// emitting a record frees exactly that run's slot
	a_emit_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_go && any_q) |=> !full_q[$past(best_idx_q)])
		else $error("emitted slot still full");

	// a done item carries no record
	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> (!m_tuser[0] && (m_tdata == '0)))
		else $error("done item carries data");

	// input is only taken while no scan or emit is in flight
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_vld_s1 || (state_q == ST_EMIT)) |-> !s_tready)
		else $error("input taken during scan");

endmodule

### rtl/kmms_ram.sv
// kmms_ram: generic single-write, single-read ram with registered read data
// no dependencies; used by kway_merge_min_select for the head records
module kmms_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
